// ===== sv/pxsm_pkg.sv =====
// Shared types and constants for the pixel map accumulator.
`timescale 1ns / 1ps

package pxsm_pkg;

    localparam int CFG_W   = 8;
    localparam int POS_W   = 4;
    localparam int COORD_W = 16;
    localparam int WORD_W  = 32;

    localparam logic [1:0] CMD_STREAM   = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_READ_CLR = 2'd2;

    localparam logic [1:0] REG_WIDTH_X  = 2'd0;
    localparam logic [1:0] REG_HEIGHT_Y = 2'd1;
    localparam logic [1:0] REG_SCALERS  = 2'd2;

    localparam logic [7:0]       WIDTH_X_RESET  = 8'd128;
    localparam logic [7:0]       HEIGHT_Y_RESET = 8'd128;
    localparam logic [POS_W-1:0] SCALERS_RESET  = 4'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic oor;
    } t_req;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [WORD_W-1:0] stream_word;
        logic [6:0]        read_x;
        logic [6:0]        read_y;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] bin_value;
        logic              accumulated;
        logic              out_of_range;
    } t_out_item;

endpackage

// ===== sv/pixel_scaler_map_accumulator.sv =====
// Pipeline: an accepted item moves through stage 1 and the output register.
// Throughput: one item per cycle when the output is not stalled; the map RAM
// read in the accept cycle and the write-back as stage 1 advances, with
// forwarding, set that figure.
// Reset: registers take their defaults, then a clearing pass over all
// MAX_COLUMNS*MAX_ROWS bins (16384 by default) zeros the map; input ready
// stays low during the pass while configuration writes are still taken.
`timescale 1ns / 1ps

module pixel_scaler_map_accumulator
    import pxsm_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128,
    parameter int BIN_WIDTH   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int MAP_BINS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW       = (MAP_BINS > 1) ? $clog2(MAP_BINS) : 1;

    logic                 accept;
    t_req                 req;
    logic [AW-1:0]        addr;
    logic [WORD_W-1:0]    word;
    logic                 ram_re;
    logic                 ready;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [BIN_WIDTH-1:0] wr_data;
    logic [BIN_WIDTH-1:0] rdata;

    pxsm_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_ready     (ready),
        .i_in_item   (i_in_item),
        .o_accept    (accept),
        .o_req       (req),
        .o_addr      (addr),
        .o_word      (word),
        .o_ram_re    (ram_re)
    );

    pxsm_ram #(
        .WIDTH (BIN_WIDTH),
        .DEPTH (MAP_BINS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    pxsm_rmw #(
        .BIN_WIDTH (BIN_WIDTH),
        .DEPTH     (MAP_BINS),
        .AW        (AW)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (req),
        .i_addr      (addr),
        .i_word      (word),
        .i_rdata     (rdata),
        .o_ready     (ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    assign o_in_ready = ready;

endmodule

// ===== sv/pxsm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pxsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pxsm_front.sv =====
// Configuration registers, record tracking and request decode.
`timescale 1ns / 1ps

module pxsm_front
    import pxsm_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128,
    parameter int AW          = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_ready,
    input  t_in_item          i_in_item,
    output logic              o_accept,
    output t_req              o_req,
    output logic [AW-1:0]     o_addr,
    output logic [WORD_W-1:0] o_word,
    output logic              o_ram_re
);

    logic [7:0]         r_wx;
    logic [7:0]         r_hy;
    logic [POS_W-1:0]   r_spp;
    logic [POS_W-1:0]   r_pos;
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;

    logic [POS_W-1:0]   n_pos;
    logic [COORD_W-1:0] n_cur_x;
    logic [COORD_W-1:0] n_cur_y;

    logic               pixel;
    logic               rd_in_store;
    logic               accept;
    t_req               req;
    logic [AW-1:0]      addr;

    function automatic logic in_extent(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [7:0] wx,
                                       input logic [7:0] hy);
        return (x < COORD_W'(wx)) && (32'(x) < 32'(MAX_COLUMNS))
            && (y < COORD_W'(hy)) && (32'(y) < 32'(MAX_ROWS));
    endfunction

    function automatic logic [AW-1:0] bin_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
        return AW'(y) * AW'(MAX_COLUMNS) + AW'(x);
    endfunction

    assign accept = i_in_valid && i_ready;

    always_comb begin
        pixel       = (r_pos == '0) || (r_pos > r_spp);
        rd_in_store = (32'(i_in_item.read_x) < 32'(MAX_COLUMNS))
                   && (32'(i_in_item.read_y) < 32'(MAX_ROWS));
        n_pos       = r_pos;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        req.op      = OP_NONE;
        req.oor     = 1'b0;
        addr        = bin_addr(r_cur_x, r_cur_y);
        unique case (i_in_item.cmd) inside
            CMD_STREAM: begin
                if (pixel) begin
                    n_cur_x = i_in_item.stream_word[31:16];
                    n_cur_y = i_in_item.stream_word[15:0];
                    req.oor = !in_extent(n_cur_x, n_cur_y, r_wx, r_hy);
                    n_pos   = (r_spp == '0) ? POS_W'(0) : POS_W'(1);
                end else begin
                    if ((r_pos == POS_W'(2)) && in_extent(r_cur_x, r_cur_y, r_wx, r_hy)) begin
                        req.op = OP_ADD;
                    end
                    n_pos = (r_pos >= r_spp) ? POS_W'(0) : r_pos + POS_W'(1);
                end
            end
            CMD_READ, CMD_READ_CLR: begin
                addr = bin_addr(COORD_W'(i_in_item.read_x), COORD_W'(i_in_item.read_y));
                if (rd_in_store) begin
                    req.op = (i_in_item.cmd == CMD_READ_CLR) ? OP_CLEAR : OP_READ;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx    <= WIDTH_X_RESET;
            r_hy    <= HEIGHT_Y_RESET;
            r_spp   <= SCALERS_RESET;
            r_pos   <= '0;
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH_X:  r_wx  <= i_cfg_data;
                    REG_HEIGHT_Y: r_hy  <= i_cfg_data;
                    REG_SCALERS:  r_spp <= i_cfg_data[POS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_pos   <= n_pos;
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
            end
        end
    end

    assign o_accept = accept;
    assign o_req    = req;
    assign o_addr   = addr;
    assign o_word   = i_in_item.stream_word;
    assign o_ram_re = accept && (req.op != OP_NONE);

endmodule

// ===== sv/pxsm_rmw.sv =====
// Read-modify-write stage with forwarding, output register and clearing pass.
`timescale 1ns / 1ps

module pxsm_rmw
    import pxsm_pkg::*;
#(
    parameter int BIN_WIDTH = 32,
    parameter int DEPTH     = 16384,
    parameter int AW        = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_req                 i_req,
    input  logic [AW-1:0]        i_addr,
    input  logic [WORD_W-1:0]    i_word,
    input  logic [BIN_WIDTH-1:0] i_rdata,
    output logic                 o_ready,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [BIN_WIDTH-1:0] o_wr_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    logic                 r_clr_done;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_s1_valid;
    t_req                 r_s1_req;
    logic [AW-1:0]        r_s1_addr;
    logic [WORD_W-1:0]    r_s1_word;
    logic                 r_fwd_hit;
    logic [BIN_WIDTH-1:0] r_fwd_data;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 s1_adv;
    logic [BIN_WIDTH-1:0] cur;
    logic                 s1_wr;
    logic [BIN_WIDTH-1:0] s1_wdata;
    t_out_item            s1_item;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [BIN_WIDTH-1:0] wr_data;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_ready = r_clr_done && (!r_s1_valid || s1_adv);
    assign cur     = r_fwd_hit ? r_fwd_data : i_rdata;

    always_comb begin
        s1_wr                = 1'b0;
        s1_wdata             = '0;
        s1_item.bin_value    = '0;
        s1_item.accumulated  = 1'b0;
        s1_item.out_of_range = r_s1_req.oor;
        case (r_s1_req.op)
            OP_ADD: begin
                s1_wr               = 1'b1;
                s1_wdata            = cur + BIN_WIDTH'(r_s1_word);
                s1_item.accumulated = 1'b1;
            end
            OP_READ: begin
                s1_item.bin_value = WORD_W'(cur);
            end
            OP_CLEAR: begin
                s1_wr             = 1'b1;
                s1_item.bin_value = WORD_W'(cur);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (!r_clr_done) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = s1_adv && s1_wr;
            wr_addr = r_s1_addr;
            wr_data = s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done  <= 1'b0;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= wr_en && (wr_addr == i_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req   <= i_req;
            r_s1_addr  <= i_addr;
            r_s1_word  <= i_word;
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out_item <= s1_item;
        end
    end

    assign o_wr_en     = wr_en;
    assign o_wr_addr   = wr_addr;
    assign o_wr_data   = wr_data;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_done |-> !i_accept)
        else $error("transfer accepted during clearing pass");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_s1_valid)
        else $error("accepted transfer missing from stage 1");

    a_wr_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (!r_clr_done || s1_adv))
        else $error("map write without clearing pass or stage advance");

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !i_accept) |=> !r_s1_valid)
        else $error("stage 1 kept an item that already advanced");

    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !wr_en) |=> !r_fwd_hit)
        else $error("forward hit without a matching write");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the pixel map accumulator: directed records, then random traffic.
`timescale 1ns / 1ps

module tb;
    import pxsm_pkg::*;

    localparam int MAP_COLS       = 128;
    localparam int MAP_ROWS       = 128;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int HOLD_OFF       = 300;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_item;

    logic [7:0]  cfg_width;
    logic [7:0]  cfg_height;
    logic [3:0]  cfg_scalers;
    logic [3:0]  rec_pos;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [31:0] map_bins [MAP_COLS*MAP_ROWS];

    t_out_item pending_results [$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_cycles;
    int        items_sent;
    int        idle_cycles;

    pixel_scaler_map_accumulator #(
        .MAX_COLUMNS(MAP_COLS),
        .MAX_ROWS   (MAP_ROWS),
        .BIN_WIDTH  (32)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic in_extent(logic [15:0] x, logic [15:0] y);
        int lim_x;
        int lim_y;
        lim_x = (cfg_width < MAP_COLS) ? int'(cfg_width) : MAP_COLS;
        lim_y = (cfg_height < MAP_ROWS) ? int'(cfg_height) : MAP_ROWS;
        return (int'(x) < lim_x) && (int'(y) < lim_y);
    endfunction

    function automatic t_out_item predict_bin_result(t_in_item it);
        t_out_item   r;
        int unsigned addr;
        r = '0;
        if (it.cmd == CMD_STREAM) begin
            if (rec_pos == 4'd0 || rec_pos > cfg_scalers) begin
                cur_x = it.stream_word[31:16];
                cur_y = it.stream_word[15:0];
                r.out_of_range = !in_extent(cur_x, cur_y);
                rec_pos = (cfg_scalers == 4'd0) ? 4'd0 : 4'd1;
            end else begin
                if (rec_pos == 4'd2 && in_extent(cur_x, cur_y)) begin
                    addr = int'(cur_y) * MAP_COLS + int'(cur_x);
                    map_bins[addr] = map_bins[addr] + it.stream_word;
                    r.accumulated = 1'b1;
                end
                rec_pos = (rec_pos >= cfg_scalers) ? 4'd0 : rec_pos + 4'd1;
            end
        end else if (it.cmd == CMD_READ || it.cmd == CMD_READ_CLR) begin
            addr = int'(it.read_y) * MAP_COLS + int'(it.read_x);
            r.bin_value = map_bins[addr];
            if (it.cmd == CMD_READ_CLR) begin
                map_bins[addr] = '0;
            end
        end
        return r;
    endfunction

    function automatic t_in_item stream_item(logic [31:0] w);
        t_in_item it;
        it.cmd         = CMD_STREAM;
        it.stream_word = w;
        it.read_x      = 7'($urandom);
        it.read_y      = 7'($urandom);
        return it;
    endfunction

    function automatic t_in_item read_item(logic [1:0] c, logic [6:0] x, logic [6:0] y);
        t_in_item it;
        it.cmd         = c;
        it.stream_word = $urandom;
        it.read_x      = x;
        it.read_y      = y;
        return it;
    endfunction

    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return 16'($urandom_range(0, 23));
        end else if (r < 88) begin
            return 16'($urandom_range(120, 135));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [6:0] pick_read_coord();
        if ($urandom_range(99) < 80) begin
            return 7'($urandom_range(0, 23));
        end
        return 7'($urandom);
    endfunction

    function automatic t_in_item random_read();
        return read_item($urandom_range(1) ? CMD_READ : CMD_READ_CLR,
                         pick_read_coord(), pick_read_coord());
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        pending_results.push_back(predict_bin_result(it));
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] x, logic [15:0] y);
        send_item(stream_item({x, y}));
    endtask

    task automatic send_scaler(logic [31:0] w);
        send_item(stream_item(w));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] wx, logic [7:0] hy, logic [7:0] sp);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WIDTH_X;
        i_cfg_data  <= wx;
        @(posedge i_clk);
        cfg_width    = wx;
        i_cfg_index <= REG_HEIGHT_Y;
        i_cfg_data  <= hy;
        @(posedge i_clk);
        cfg_height   = hy;
        i_cfg_index <= REG_SCALERS;
        i_cfg_data  <= sp;
        @(posedge i_clk);
        cfg_scalers  = sp[3:0];
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_records(int count);
        int stop_at;
        int pick;
        int k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(random_read());
            end else if (pick < 10) begin
                send_item(read_item(CMD_UNUSED, 7'($urandom), 7'($urandom)));
            end else if (pick < 14) begin
                send_scaler($urandom);
            end else begin
                if (pick < 25) begin
                    send_scaler($urandom);
                end else begin
                    send_pixel(pick_coord(), pick_coord());
                end
                for (k = 0; k < cfg_scalers; k++) begin
                    if ($urandom_range(99) < 4) break;
                    if ($urandom_range(99) < 5) send_item(random_read());
                    send_scaler($urandom);
                end
            end
        end
    endtask

    task automatic test_directed_records();
        send_pixel(16'd0, 16'd0);
        send_scaler(32'h1234_5678);
        send_scaler(32'hFFFF_FFFF);
        send_pixel(16'd0, 16'd0);
        send_scaler(32'h0);
        send_scaler(32'h2);
        send_item(read_item(CMD_READ, 7'd0, 7'd0));
        send_pixel(16'd127, 16'd127);
        send_scaler(32'h5A5A_A5A5);
        send_scaler(32'h8000_0000);
        send_item(read_item(CMD_READ_CLR, 7'd127, 7'd127));
        send_item(read_item(CMD_READ, 7'd127, 7'd127));
        send_pixel(16'd128, 16'd5);
        send_scaler($urandom);
        send_scaler(32'h1);
        send_pixel(16'd5, 16'd128);
        send_scaler($urandom);
        send_scaler(32'h1);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_scaler($urandom);
        send_scaler(32'h1);
        send_item(read_item(CMD_UNUSED, 7'($urandom), 7'($urandom)));
        send_item(read_item(CMD_READ, 7'd5, 7'd5));
    endtask

    task automatic test_no_scalers();
        int k;
        set_config(8'd128, 8'd128, 8'h00);
        send_pixel(16'd3, 16'd4);
        send_pixel(16'd200, 16'd1);
        send_pixel(16'd0, 16'h8000);
        send_item(read_item(CMD_READ, 7'd3, 7'd4));
        set_config(8'd0, 8'd0, 8'hA0);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd1, 16'd0);
        set_config(8'hFF, 8'hFF, 8'h0F);
        send_pixel(16'd127, 16'd127);
        for (k = 0; k < 15; k++) begin
            send_scaler((k == 1) ? 32'h3 : $urandom);
        end
        send_pixel(16'd128, 16'd0);
        send_item(read_item(CMD_READ_CLR, 7'd127, 7'd127));
    endtask

    task automatic test_mid_record_changes();
        set_config(8'd128, 8'd128, 8'h05);
        send_pixel(16'd10, 16'd10);
        send_scaler($urandom);
        send_scaler(32'h7);
        send_scaler($urandom);
        set_config(8'd128, 8'd128, 8'h02);
        send_pixel(16'd11, 16'd11);
        send_scaler($urandom);
        send_scaler(32'h9);
        send_item(read_item(CMD_READ, 7'd11, 7'd11));
        send_item(read_item(CMD_READ, 7'd10, 7'd10));
        set_config(8'd128, 8'd128, 8'h03);
        send_pixel(16'd50, 16'd50);
        send_scaler($urandom);
        set_config(8'd10, 8'd128, 8'h03);
        send_scaler(32'h1);
        send_scaler($urandom);
        send_pixel(16'd20, 16'd5);
        set_config(8'd128, 8'd128, 8'h03);
        send_scaler($urandom);
        send_scaler(32'h4);
        send_scaler($urandom);
        send_item(read_item(CMD_READ_CLR, 7'd50, 7'd50));
        send_item(read_item(CMD_READ_CLR, 7'd20, 7'd5));
    endtask

    task automatic test_backpressure();
        set_config(8'd128, 8'd128, 8'h02);
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = HOLD_OFF;
        run_records(60);
        settle();
    endtask

    task automatic test_random_phase(logic [7:0] wx, logic [7:0] hy, logic [7:0] sp,
                                     int send_pct, int stall_pct, int count);
        set_config(wx, hy, sp);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        run_records(count);
    endtask

    task automatic test_random_traffic();
        test_random_phase(8'd128, 8'd128, 8'h02, 0, 0, 340);
        test_random_phase(8'd100, 8'd60, 8'h03, 58, 0, 340);
        test_random_phase(8'd128, 8'd128, 8'h01, 0, 58, 340);
        test_random_phase(8'd20, 8'd12, 8'hF4, 31, 31, 340);
        test_random_phase(8'd255, 8'd255, 8'h0F, 31, 31, 200);
        test_random_phase(8'd7, 8'd128, 8'h02, 0, 0, 150);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : check_results
        t_out_item want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing pending, got %h", $time, o_out_item);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.bin_value !== want.bin_value) begin
                        $display("%0t: bin_value expected %h, got %h",
                                 $time, want.bin_value, o_out_item.bin_value);
                        errors++;
                    end
                    if (o_out_item.accumulated !== want.accumulated) begin
                        $display("%0t: accumulated expected %b, got %b",
                                 $time, want.accumulated, o_out_item.accumulated);
                        errors++;
                    end
                    if (o_out_item.out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range expected %b, got %b",
                                 $time, want.out_of_range, o_out_item.out_of_range);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_WIDTH_X;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_item       = '0;
        i_out_ready     = 1'b0;
        errors          = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        cfg_width       = WIDTH_X_RESET;
        cfg_height      = HEIGHT_Y_RESET;
        cfg_scalers     = SCALERS_RESET;
        rec_pos         = '0;
        cur_x           = '0;
        cur_y           = '0;
        foreach (map_bins[a]) map_bins[a] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_records();
        test_no_scalers();
        test_mid_record_changes();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pxsm_pkg.sv
sv/pxsm_ram.sv
sv/pxsm_front.sv
sv/pxsm_rmw.sv
sv/pixel_scaler_map_accumulator.sv
bench/tb.sv
